@@ hw/rtl/camera_primary_ray_generator_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the primary ray generator
// Concurrent checks on a clock with an active-low asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef CAMERA_PRIMARY_RAY_GENERATOR_CORE_ASSERT_SVH
`define CAMERA_PRIMARY_RAY_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define CPRG_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cprg assertion failed");

// next-cycle implication
`define CPRG_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cprg assertion failed");

`endif

@@ hw/rtl/cprg_pkg.sv @@
// ---------------------------------------------------------------------------
// cprg_pkg
// Shared constants, types and helpers of the primary ray generator.
// ---------------------------------------------------------------------------
package cprg_pkg;

  localparam int MaxImageSide = 4096;
  localparam int PixW         = 12;
  localparam int PixMax       = MaxImageSide - 1;

  localparam int CfgIdxW = 3;
  localparam int CfgW    = 60;

  localparam logic [CfgIdxW-1:0] CfgPixelSize  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHalfWidth  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHalfHeight = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRowX       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRowY       = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRowZ       = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgOrigin     = 3'd6;

  localparam logic [47:0] RowXReset = 48'h0000_0000_1000;
  localparam logic [47:0] RowYReset = 48'h0000_1000_0000;
  localparam logic [47:0] RowZReset = 48'h1000_0000_0000;

  localparam int OrgW  = 20;
  localparam int DirW  = 16;
  localparam int DotW  = 64;  // direction component, Q.37
  localparam int MagW  = 63;
  localparam int MsbW  = 6;
  localparam int NrmW  = 30;  // normalized magnitude, largest lane in [2^29, 2^30)
  localparam int SumW  = 62;
  localparam int RootW = 31;
  localparam int RemW  = 33;
  localparam int FracW = 15;
  localparam int QW    = 16;
  localparam int NumW  = NrmW + FracW + 1;

  localparam logic [DirW-1:0] DirPosMax = 16'h7fff;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;

  typedef struct packed {
    logic [31:0] pix_pitch;
    logic [31:0] half_w;
    logic [31:0] half_h;
    logic [47:0] row_x;
    logic [47:0] row_y;
    logic [47:0] row_z;
    logic [59:0] origin;
  } cfg_t;

  typedef struct packed {
    logic [2:0][DotW-1:0] d;
  } dir_t;

  typedef struct packed {
    logic [2:0]           sgn;
    logic                 degen;
    logic [2:0][NrmW-1:0] mag;
  } side_t;

  typedef struct packed {
    logic signed [OrgW-1:0] origin_x;
    logic signed [OrgW-1:0] origin_y;
    logic signed [OrgW-1:0] origin_z;
    logic signed [DirW-1:0] direction_x;
    logic signed [DirW-1:0] direction_y;
    logic signed [DirW-1:0] direction_z;
    logic                   degenerate;
  } ray_t;

  function automatic logic [PixW-1:0] clamp_pix(input logic [PixW-1:0] p);
    logic [PixW:0] lim;
    lim = (PixW+1)'(PixMax);
    return ({1'b0, p} > lim) ? lim[PixW-1:0] : p;
  endfunction

endpackage

@@ hw/rtl/cprg_if.sv @@
// ---------------------------------------------------------------------------
// cprg interfaces
// Valid/ready channels for pixel words and ray words.
// ---------------------------------------------------------------------------
interface cprg_pix_if;
  logic                       valid;
  logic                       ready;
  logic [cprg_pkg::PixW-1:0]  pixel_x;
  logic [cprg_pkg::PixW-1:0]  pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface cprg_ray_if;
  logic                              valid;
  logic                              ready;
  logic signed [cprg_pkg::OrgW-1:0]  origin_x;
  logic signed [cprg_pkg::OrgW-1:0]  origin_y;
  logic signed [cprg_pkg::OrgW-1:0]  origin_z;
  logic signed [cprg_pkg::DirW-1:0]  direction_x;
  logic signed [cprg_pkg::DirW-1:0]  direction_y;
  logic signed [cprg_pkg::DirW-1:0]  direction_z;
  logic                              degenerate;

  modport source (output valid, output origin_x, output origin_y, output origin_z,
                  output direction_x, output direction_y, output direction_z,
                  output degenerate, input ready);
  modport sink   (input valid, input origin_x, input origin_y, input origin_z,
                  input direction_x, input direction_y, input direction_z,
                  input degenerate, output ready);
endinterface

@@ hw/rtl/camera_primary_ray_generator_core.sv @@
// ---------------------------------------------------------------------------
// camera_primary_ray_generator_core
// Pinhole camera: pixel word in, ray word (origin, unit direction) out.
//
//   channel  dir  word                         handshake
//   pix_i    in   pixel_x, pixel_y             valid/ready
//   ray_o    out  origin xyz, direction xyz,   valid/ready
//                 degenerate
//   cfg      in   cfg_idx_i, cfg_data_i        cfg_we_i, no stall
//
// One word per clock in steady state while ray_o is ready; a ray word, once
// its pixel word is accepted, passes 3 front stages (the first loads at the
// accepting edge), one FIFO slot, 54 back stages (31 square root bits,
// 16 quotient bits) and the output register.
// The FIFO lets front and back stall separately.
// Reset clears valids and loads the identity matrix; no clearing pass.
// ---------------------------------------------------------------------------
module camera_primary_ray_generator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cprg_pix_if.sink                     pix_i,
  cprg_ray_if.source                   ray_o,
  input  logic                         cfg_we_i,
  input  logic [cprg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cprg_pkg::CfgW-1:0]    cfg_data_i
);
  import cprg_pkg::*;

  cfg_t cfg_q;
  logic fr_valid, fr_ready, bk_valid, bk_ready;
  dir_t fr_dir, bk_dir;
  ray_t ray;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pix_pitch <= '0;
      cfg_q.half_w    <= '0;
      cfg_q.half_h    <= '0;
      cfg_q.row_x     <= RowXReset;
      cfg_q.row_y     <= RowYReset;
      cfg_q.row_z     <= RowZReset;
      cfg_q.origin    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPixelSize:  cfg_q.pix_pitch <= cfg_data_i[31:0];
        CfgHalfWidth:  cfg_q.half_w    <= cfg_data_i[31:0];
        CfgHalfHeight: cfg_q.half_h    <= cfg_data_i[31:0];
        CfgRowX:       cfg_q.row_x     <= cfg_data_i[47:0];
        CfgRowY:       cfg_q.row_y     <= cfg_data_i[47:0];
        CfgRowZ:       cfg_q.row_z     <= cfg_data_i[47:0];
        CfgOrigin:     cfg_q.origin    <= cfg_data_i[59:0];
        default: ;
      endcase
    end
  end

  cprg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .pixel_x_i   (pix_i.pixel_x),
    .pixel_y_i   (pix_i.pixel_y),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_dir_o   (fr_dir)
  );

  cprg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_dir_i    (fr_dir),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_dir_o   (bk_dir)
  );

  cprg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_dir_i    (bk_dir),
    .origin_i    (cfg_q.origin),
    .out_valid_o (ray_o.valid),
    .out_ready_i (ray_o.ready),
    .out_ray_o   (ray)
  );

  assign ray_o.origin_x    = ray.origin_x;
  assign ray_o.origin_y    = ray.origin_y;
  assign ray_o.origin_z    = ray.origin_z;
  assign ray_o.direction_x = ray.direction_x;
  assign ray_o.direction_y = ray.direction_y;
  assign ray_o.direction_z = ray.direction_z;
  assign ray_o.degenerate  = ray.degenerate;

endmodule

@@ hw/rtl/cprg_fifo.sv @@
// ---------------------------------------------------------------------------
// cprg_fifo
// Small register FIFO of direction words between front and back.
// ---------------------------------------------------------------------------
module cprg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cprg_pkg::dir_t in_dir_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cprg_pkg::dir_t out_dir_o
);
  import cprg_pkg::*;

  dir_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                push, pop;

  assign in_ready_o  = (cnt_q != (FifoPtrW+1)'(FifoDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_dir_o   = mem_q[rd_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoPtrW+1)'(push) - (FifoPtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_dir_i;
  end

endmodule

@@ hw/rtl/cprg_front.sv @@
// ---------------------------------------------------------------------------
// cprg_front
// Pixel to canvas point, then the 3x3 linear map to a raw direction.
// ---------------------------------------------------------------------------
module cprg_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cprg_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [cprg_pkg::PixW-1:0] pixel_x_i,
  input  logic [cprg_pkg::PixW-1:0] pixel_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output cprg_pkg::dir_t            out_dir_o
);
  import cprg_pkg::*;

  logic        en;
  logic [2:0]  v_q;

  // canvas point, Q.25, 47 bits
  logic [PixW:0]   ox, oy;
  logic [44:0]     tx, ty;
  logic [46:0]     wx_d, wy_d, wx_q, wy_q;

  logic [2:0][47:0]   rows;
  logic signed [40:0] plo_d [3][2];
  logic signed [38:0] phi_d [3][2];
  logic signed [40:0] plo_q [3][2];
  logic signed [38:0] phi_q [3][2];
  logic [1:0][46:0]   w;
  dir_t               dir_d, dir_q;

  assign en          = ~v_q[2] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[2];
  assign out_dir_o   = dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  // 2*half - (2p+1)*pixel pitch
  always_comb begin
    ox   = {clamp_pix(pixel_x_i), 1'b1};
    oy   = {clamp_pix(pixel_y_i), 1'b1};
    tx   = ox * cfg_i.pix_pitch;
    ty   = oy * cfg_i.pix_pitch;
    wx_d = {{14{cfg_i.half_w[31]}}, cfg_i.half_w, 1'b0} - {2'b00, tx};
    wy_d = {{14{cfg_i.half_h[31]}}, cfg_i.half_h, 1'b0} - {2'b00, ty};
  end

  // partial products, canvas split in 24 low and 23 high bits
  always_comb begin
    rows = {cfg_i.row_z, cfg_i.row_y, cfg_i.row_x};
    w    = {wy_q, wx_q};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 2; c++) begin
        plo_d[r][c] = $signed(rows[r][16*c +: 16]) * $signed({1'b0, w[c][23:0]});
        phi_d[r][c] = $signed(rows[r][16*c +: 16]) * $signed(w[c][46:24]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dir_d.d[r] = (64'(phi_q[r][0]) <<< 24) + 64'(plo_q[r][0])
                 + (64'(phi_q[r][1]) <<< 24) + 64'(plo_q[r][1])
                 - (64'($signed(rows[r][47:32])) <<< 25);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q  <= wx_d;
      wy_q  <= wy_d;
      plo_q <= plo_d;
      phi_q <= phi_d;
      dir_q <= dir_d;
    end
  end

endmodule

@@ hw/rtl/cprg_back.sv @@
// ---------------------------------------------------------------------------
// cprg_back
// Normalize, square root and per-lane division to a unit direction.
// ---------------------------------------------------------------------------
module cprg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cprg_pkg::dir_t in_dir_i,
  input  logic [59:0]    origin_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cprg_pkg::ray_t out_ray_o
);
  import cprg_pkg::*;

  localparam int SqBase  = 6;
  localparam int DvPrep  = SqBase + RootW;
  localparam int DvBase  = DvPrep + 1;
  localparam int NBack   = DvBase + QW;

  logic              en;
  logic [NBack-1:0]  vld_q;
  logic              ovalid_q;
  ray_t              ray_q;

  assign en          = ~ovalid_q | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = ovalid_q;
  assign out_ray_o   = ray_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ovalid_q <= 1'b0;
    end else if (en) begin
      vld_q    <= {vld_q[NBack-2:0], in_valid_i};
      ovalid_q <= vld_q[NBack-1];
    end
  end

  // ---- magnitude and sign
  logic [2:0][DotW-1:0] abs_d;
  logic [2:0]           sgn0_q, sgn1_q, sgn2_q;
  logic [2:0][MagW-1:0] mag0_q, mag1_q, mag2_q;
  logic [MagW-1:0]      mx_d, mx1_q;
  logic [MsbW-1:0]      msb_d, msb2_q;
  logic                 zero2_q;
  logic [2:0][MagW-1:0] wide;
  side_t                side_d, side3_q, side4_q, side5_q;
  logic [2:0][2*NrmW-1:0] sq4_q;
  logic [SumW-1:0]      sum5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_d[i] = in_dir_i.d[i][DotW-1] ? (DotW'(0) - in_dir_i.d[i]) : in_dir_i.d[i];
    end
    mx_d = (mag0_q[0] > mag0_q[1]) ? mag0_q[0] : mag0_q[1];
    if (mag0_q[2] > mx_d) mx_d = mag0_q[2];
    msb_d = '0;
    for (int b = 0; b < MagW; b++) begin
      if (mx1_q[b]) msb_d = MsbW'(b);
    end
    // scale so the largest lies in [2^29, 2^30)
    for (int i = 0; i < 3; i++) begin
      if (msb2_q >= MsbW'(NrmW-1)) wide[i] = mag2_q[i] >> (msb2_q - MsbW'(NrmW-1));
      else                         wide[i] = mag2_q[i] << (MsbW'(NrmW-1) - msb2_q);
      side_d.mag[i] = wide[i][NrmW-1:0];
    end
    side_d.sgn   = sgn2_q;
    side_d.degen = zero2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sgn0_q[i] <= in_dir_i.d[i][DotW-1];
        mag0_q[i] <= abs_d[i][MagW-1:0];
        sq4_q[i]  <= (2*NrmW)'(side3_q.mag[i]) * (2*NrmW)'(side3_q.mag[i]);
      end
      sgn1_q  <= sgn0_q;
      mag1_q  <= mag0_q;
      mx1_q   <= mx_d;
      sgn2_q  <= sgn1_q;
      mag2_q  <= mag1_q;
      msb2_q  <= msb_d;
      zero2_q <= (mx1_q == '0);
      side3_q <= side_d;
      side4_q <= side3_q;
      side5_q <= side4_q;
      sum5_q  <= SumW'(sq4_q[0]) + SumW'(sq4_q[1]) + SumW'(sq4_q[2]);
    end
  end

  // ---- square root, one result bit per stage
  logic [SumW-1:0]  rt_rad_q  [RootW];
  logic [RemW-1:0]  rt_rem_q  [RootW];
  logic [RootW-1:0] rt_root_q [RootW];
  side_t            rt_side_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic [SumW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    side_t            side;
    logic [RemW+1:0]  rem_t, trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad  = sum5_q;
      assign rem  = '0;
      assign root = '0;
      assign side = side5_q;
    end else begin : g_next
      assign rad  = rt_rad_q[k-1];
      assign rem  = rt_rem_q[k-1];
      assign root = rt_root_q[k-1];
      assign side = rt_side_q[k-1];
    end

    assign rem_t = {rem, rad[SumW-1 -: 2]};
    assign trial = {2'b00, root, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_rad_q[k]  <= {rad[SumW-3:0], 2'b00};
        rt_rem_q[k]  <= ge ? RemW'(rem_t - trial) : rem_t[RemW-1:0];
        rt_root_q[k] <= {root[RootW-2:0], ge};
        rt_side_q[k] <= side;
      end
    end
  end

  // ---- rounding bias, then restoring division in three lanes
  logic [RootW-1:0]     pv_len_q;
  logic [2:0][NumW-1:0] pv_num_q;
  side_t                pv_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pv_len_q  <= rt_root_q[RootW-1];
      pv_side_q <= rt_side_q[RootW-1];
      for (int i = 0; i < 3; i++) begin
        pv_num_q[i] <= NumW'({rt_side_q[RootW-1].mag[i], {FracW{1'b0}}})
                     + NumW'(rt_root_q[RootW-1] >> 1);
      end
    end
  end

  logic [2:0][RootW-1:0] dv_rem_q  [QW];
  logic [2:0][QW-1:0]    dv_low_q  [QW];
  logic [2:0][QW-1:0]    dv_quo_q  [QW];
  logic [RootW-1:0]      dv_len_q  [QW];
  side_t                 dv_side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [2:0][RootW-1:0] rem;
    logic [2:0][QW-1:0]    low, quo;
    logic [RootW-1:0]      len;
    side_t                 side;
    logic [2:0][RootW:0]   rem_t;
    logic [2:0]            ge;

    if (k == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem[i] = RootW'(pv_num_q[i][NumW-1:QW]);
        assign low[i] = pv_num_q[i][QW-1:0];
      end
      assign quo  = '0;
      assign len  = pv_len_q;
      assign side = pv_side_q;
    end else begin : g_next
      assign rem  = dv_rem_q[k-1];
      assign low  = dv_low_q[k-1];
      assign quo  = dv_quo_q[k-1];
      assign len  = dv_len_q[k-1];
      assign side = dv_side_q[k-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_step
      assign rem_t[i] = {rem[i], low[i][QW-1]};
      assign ge[i]    = (rem_t[i] >= {1'b0, len});
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[k][i] <= ge[i] ? RootW'(rem_t[i] - {1'b0, len}) : rem_t[i][RootW-1:0];
          dv_low_q[k][i] <= {low[i][QW-2:0], 1'b0};
          dv_quo_q[k][i] <= {quo[i][QW-2:0], ge[i]};
        end
        dv_len_q[k]  <= len;
        dv_side_q[k] <= side;
      end
    end
  end

  // ---- sign, saturation, output word
  logic [2:0][DirW-1:0] dir_d;
  side_t                fin;

  always_comb begin
    fin = dv_side_q[QW-1];
    for (int i = 0; i < 3; i++) begin
      if (fin.degen)       dir_d[i] = '0;
      else if (fin.sgn[i]) dir_d[i] = DirW'(0) - dv_quo_q[QW-1][i];
      else if (dv_quo_q[QW-1][i][QW-1]) dir_d[i] = DirPosMax;
      else                 dir_d[i] = dv_quo_q[QW-1][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray_q.origin_x    <= origin_i[19:0];
      ray_q.origin_y    <= origin_i[39:20];
      ray_q.origin_z    <= origin_i[59:40];
      ray_q.direction_x <= dir_d[0];
      ray_q.direction_y <= dir_d[1];
      ray_q.direction_z <= dir_d[2];
      ray_q.degenerate  <= fin.degen;
    end
  end

endmodule

@@ hw/rtl/cprg_checker.sv @@
// ---------------------------------------------------------------------------
// cprg_checker
// Port-level checks on the ray channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "camera_primary_ray_generator_core_assert.svh"

module cprg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         ray_valid_i,
  input logic                         ray_ready_i,
  input logic                         degenerate_i,
  input logic [cprg_pkg::DirW-1:0]    dir_x_i,
  input logic [cprg_pkg::DirW-1:0]    dir_y_i,
  input logic [cprg_pkg::DirW-1:0]    dir_z_i
);
  // a zero-length direction goes out as zero
  `CPRG_ASSERT_NOW(a_degen_zero, clk_i, rst_ni, ray_valid_i && degenerate_i, dir_x_i == '0 && dir_y_i == '0 && dir_z_i == '0)
  // a non-degenerate direction has a nonzero component
  `CPRG_ASSERT_NOW(a_unit_nonzero, clk_i, rst_ni, ray_valid_i && !degenerate_i, dir_x_i != '0 || dir_y_i != '0 || dir_z_i != '0)
  `CPRG_ASSERT_NEXT(a_ray_hold, clk_i, rst_ni, ray_valid_i && !ray_ready_i, ray_valid_i)
endmodule

bind camera_primary_ray_generator_core cprg_checker u_cprg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .ray_valid_i  (ray_o.valid),
  .ray_ready_i  (ray_o.ready),
  .degenerate_i (ray_o.degenerate),
  .dir_x_i      (ray_o.direction_x),
  .dir_y_i      (ray_o.direction_y),
  .dir_z_i      (ray_o.direction_z)
);

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Streams pixel words through the primary ray generator over several camera
// setups. Expected ray words come from an in-bench predictor and are checked
// field by field in order. Both sides stall at random outside one no-idle phase.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cprg_pkg::*;

  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 3'd7;

  class ray_board;
    ray_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note(ray_t r);
      pending.push_back(r);
    endfunction

    task cmp(string field, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    task check(ray_t got);
      ray_t want;
      if (pending.size() == 0) begin
        report("ray word with none pending");
        return;
      end
      want = pending.pop_front();
      cmp("origin_x", got.origin_x, want.origin_x);
      cmp("origin_y", got.origin_y, want.origin_y);
      cmp("origin_z", got.origin_z, want.origin_z);
      cmp("direction_x", got.direction_x, want.direction_x);
      cmp("direction_y", got.direction_y, want.direction_y);
      cmp("direction_z", got.direction_z, want.direction_z);
      cmp("degenerate", got.degenerate, want.degenerate);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  cprg_pix_if pix();
  cprg_ray_if ray();

  camera_primary_ray_generator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .pix_i(pix), .ray_o(ray),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // shadow copy of the camera registers
  logic [31:0] sh_pix_size, sh_half_w, sh_half_h;
  logic [47:0] sh_row [3];
  logic [59:0] sh_origin;

  ray_board board;
  bit no_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic ray_t predict_ray(logic [PixW-1:0] px_in, logic [PixW-1:0] py_in);
    ray_t r;
    longint px, py, ps, wx, wy;
    longint d [3];
    longint unsigned mag [3];
    longint unsigned mx, sum, len, q;
    int bits;
    px = (px_in > PixMax) ? PixMax : px_in;
    py = (py_in > PixMax) ? PixMax : py_in;
    ps = longint'({32'b0, sh_pix_size});
    wx = 2 * longint'($signed(sh_half_w)) - (2 * px + 1) * ps;
    wy = 2 * longint'($signed(sh_half_h)) - (2 * py + 1) * ps;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      // z of the canvas point is -1.0 in Q.25
      d[i] = longint'($signed(sh_row[i][15:0])) * wx
           + longint'($signed(sh_row[i][31:16])) * wy
           - longint'($signed(sh_row[i][47:32])) * 64'sd33554432;
      mag[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
      if (mag[i] > mx) mx = mag[i];
    end
    r.origin_x = sh_origin[19:0];
    r.origin_y = sh_origin[39:20];
    r.origin_z = sh_origin[59:40];
    if (mx == 0) begin
      r.direction_x = '0;
      r.direction_y = '0;
      r.direction_z = '0;
      r.degenerate = 1'b1;
      return r;
    end
    bits = 0;
    while (mx != 0) begin
      bits++;
      mx >>= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (bits > 30) mag[i] >>= (bits - 30);
      else mag[i] <<= (30 - bits);
      sum += mag[i] * mag[i];
    end
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      logic [DirW-1:0] v;
      q = ((mag[i] << 15) + (len >> 1)) / len;
      if (d[i] < 0) begin
        if (q > 32768) q = 32768;
        v = DirW'(-longint'(q));
      end else begin
        if (q > 32767) q = 32767;
        v = DirW'(q);
      end
      case (i)
        0: r.direction_x = v;
        1: r.direction_y = v;
        default: r.direction_z = v;
      endcase
    end
    r.degenerate = 1'b0;
    return r;
  endfunction

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready) board.note(predict_ray(pix.pixel_x, pix.pixel_y));
      if (ray.valid && ray.ready) begin
        ray_t got;
        got.origin_x = ray.origin_x;
        got.origin_y = ray.origin_y;
        got.origin_z = ray.origin_z;
        got.direction_x = ray.direction_x;
        got.direction_y = ray.direction_y;
        got.direction_z = ray.direction_z;
        got.degenerate = ray.degenerate;
        board.check(got);
      end
    end
  end

  always @(negedge clk_i) ray.ready = no_idle || ($urandom_range(0, 99) >= 36);

  task write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      CfgPixelSize: sh_pix_size = data[31:0];
      CfgHalfWidth: sh_half_w = data[31:0];
      CfgHalfHeight: sh_half_h = data[31:0];
      CfgRowX: sh_row[0] = data[47:0];
      CfgRowY: sh_row[1] = data[47:0];
      CfgRowZ: sh_row[2] = data[47:0];
      CfgOrigin: sh_origin = data[59:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task send_pixel(logic [PixW-1:0] x, logic [PixW-1:0] y);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      pix.valid = 1'b0;
      @(negedge clk_i);
    end
    pix.valid = 1'b1;
    pix.pixel_x = x;
    pix.pixel_y = y;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
    pix.valid = 1'b0;
  endtask

  task drain;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_q824();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task random_setup;
    write_reg(CfgPixelSize, CfgW'(rand_q824()));
    write_reg(CfgHalfWidth, CfgW'(rand_q824()));
    write_reg(CfgHalfHeight, CfgW'(rand_q824()));
    write_reg(CfgRowX, CfgW'({rand_entry(), rand_entry(), rand_entry()}));
    write_reg(CfgRowY, CfgW'({rand_entry(), rand_entry(), rand_entry()}));
    write_reg(CfgRowZ, CfgW'({rand_entry(), rand_entry(), rand_entry()}));
    write_reg(CfgOrigin, CfgW'({$urandom, $urandom}));
  endtask

  task corner_pixels;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd0, 12'hfff);
    send_pixel(12'hfff, 12'd0);
    send_pixel(12'h555, 12'haaa);
  endtask

  initial begin
    board = new();
    no_idle = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    ray.ready = 1'b0;
    sh_pix_size = '0;
    sh_half_w = '0;
    sh_half_h = '0;
    sh_row[0] = RowXReset;
    sh_row[1] = RowYReset;
    sh_row[2] = RowZReset;
    sh_origin = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // identity camera: straight down -z, minus one
    corner_pixels();
    drain();
    // zero matrix: zero-length direction
    write_reg(CfgRowX, '0);
    write_reg(CfgRowY, '0);
    write_reg(CfgRowZ, '0);
    write_reg(CfgOrigin, {20'h80000, 20'h7ffff, 20'h12345});
    corner_pixels();
    drain();
    // flipped z row: plus one saturates
    write_reg(CfgRowZ, 48'hf000_0000_0000);
    write_reg(CfgPixelSize, '0);
    send_pixel(12'd7, 12'd9);
    send_pixel(12'hfff, 12'd0);
    drain();
    // extremes of every register
    write_reg(CfgPixelSize, 32'hffff_ffff);
    write_reg(CfgHalfWidth, 32'h8000_0000);
    write_reg(CfgHalfHeight, 32'h7fff_ffff);
    write_reg(CfgRowX, 48'h8000_7fff_8000);
    write_reg(CfgRowY, 48'h7fff_8000_7fff);
    write_reg(CfgRowZ, 48'hffff_ffff_ffff);
    write_reg(CfgOrigin, '1);
    write_reg(CfgUnmapped, '1);  // ignored
    corner_pixels();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_setup();
      if (ph == 2) write_reg(CfgUnmapped, CfgW'({$urandom, $urandom}));
      no_idle = (ph == 3);
      for (int n = 0; n < 232; n++) begin
        if (ph == 4 && n == 116) begin
          while (board.pending.size() != 0) @(negedge clk_i);
        end
        if ($urandom_range(0, 9) == 0) send_pixel($urandom_range(0, 1) ? 12'hfff : 12'd0,
                                                 12'($urandom));
        else send_pixel(12'($urandom), 12'($urandom));
      end
      drain();
    end
    no_idle = 1'b0;

    if (board.pending.size() != 0) board.report("ray words never arrived");
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cprg_pkg.sv
hw/rtl/cprg_if.sv
hw/rtl/cprg_fifo.sv
hw/rtl/cprg_front.sv
hw/rtl/cprg_back.sv
hw/rtl/camera_primary_ray_generator_core.sv
hw/rtl/cprg_checker.sv
tb/sv/testbench.sv
